>>> rtl/xml_entity_decoder_top_macros.svh
// assertion macros shared by the checker
`ifndef XML_ENTITY_DECODER_TOP_MACROS_SVH
`define XML_ENTITY_DECODER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define XED_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xed check failed");

// next-cycle implication, sampled on clk, off while in reset
`define XED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xed check failed");

`endif

>>> rtl/xed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xed_pkg;

    localparam int EntCount    = 5;
    localparam int EntMaxLen   = 5;
    localparam int PrefixDepth = 4;
    localparam int BurstDepth  = 6;

    typedef logic [7:0] byte_t;

    localparam byte_t AMP_CHAR = 8'h26;

    // entity names without the leading ampersand, zero padded
    localparam byte_t ENT_NAME [EntCount][EntMaxLen] = '{
        '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},   // lt;
        '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},   // gt;
        '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},   // amp;
        '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},   // apos;
        '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b}    // quot;
    };

    localparam logic [2:0] ENT_LEN [EntCount] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};

    localparam byte_t ENT_RAW [EntCount] = '{8'h3c, 8'h3e, 8'h26, 8'h27, 8'h22};

    // result bytes of one request, slot 0 goes out first
    typedef struct packed {
        byte_t [BurstDepth-1:0] data;
        logic [2:0]             count;
        logic                   last;
    } burst_t;

    // state update produced by the matcher
    typedef struct packed {
        logic       in_entity;
        logic [2:0] count;
        logic       wr_en;
        logic [1:0] wr_idx;
    } state_upd_t;

endpackage

`default_nettype wire

>>> rtl/xed_match.sv
`timescale 1ns / 1ps
`default_nettype none

module xed_match
    import xed_pkg::*;
(
    input  wire logic                    in_entity,
    input  wire logic [2:0]              prefix_count,
    input  wire byte_t [PrefixDepth-1:0] prefix_bytes,
    input  wire byte_t                   char_in,
    input  wire logic                    last_in,
    output burst_t                       burst,
    output state_upd_t                   upd
);

    logic [EntCount-1:0] hit;
    logic [EntCount-1:0] full_hit;
    logic                full;
    logic                partial;
    logic                flush;
    logic                append_c;
    byte_t               raw;

    always_comb
    begin
        for (int e = 0; e < EntCount; e++)
        begin
            hit[e] = (ENT_LEN[e] > prefix_count) && (ENT_NAME[e][prefix_count] == char_in);
            for (int i = 0; i < PrefixDepth; i++)
            begin
                if ((i < int'(prefix_count)) && (prefix_bytes[i] != ENT_NAME[e][i]))
                begin
                    hit[e] = 1'b0;
                end
            end
            full_hit[e] = hit[e] && (ENT_LEN[e] == prefix_count + 3'd1);
        end
    end

    always_comb
    begin
        raw = AMP_CHAR;
        for (int e = 0; e < EntCount; e++)
        begin
            if (full_hit[e])
            begin
                raw = ENT_RAW[e];
            end
        end
    end

    assign full    = in_entity && (|full_hit);
    assign partial = in_entity && (|(hit & ~full_hit))
                     && (prefix_count < 3'(PrefixDepth));
    // pending prefix goes out unchanged: mismatch, or stream ends inside a prefix
    assign flush    = in_entity && !full && !(partial && !last_in);
    // a fresh ampersand opens a prefix instead of going out
    assign append_c = !((char_in == AMP_CHAR) && !last_in);

    always_comb
    begin
        for (int j = 0; j < BurstDepth; j++)
        begin
            burst.data[j] = char_in;
        end
        burst.last  = last_in;
        burst.count = 3'd0;
        if (full)
        begin
            burst.data[0] = raw;
            burst.count   = 3'd1;
        end
        else if (partial && !last_in)
        begin
            burst.count = 3'd0;
        end
        else if (flush)
        begin
            burst.data[0] = AMP_CHAR;
            for (int j = 1; j < BurstDepth; j++)
            begin
                if ((j - 1) < int'(prefix_count))
                begin
                    burst.data[j] = prefix_bytes[j-1];
                end
            end
            burst.count = prefix_count + 3'd1 + {2'b00, append_c};
        end
        else
        begin
            burst.count = {2'b00, append_c};
        end
    end

    always_comb
    begin
        upd.wr_en     = partial;
        upd.wr_idx    = prefix_count[1:0];
        upd.in_entity = 1'b0;
        upd.count     = 3'd0;
        if (last_in || full)
        begin
            upd.in_entity = 1'b0;
            upd.count     = 3'd0;
        end
        else if (partial)
        begin
            upd.in_entity = 1'b1;
            upd.count     = prefix_count + 3'd1;
        end
        else
        begin
            upd.in_entity = (char_in == AMP_CHAR);
            upd.count     = 3'd0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/xed_burst.sv
`timescale 1ns / 1ps
`default_nettype none

module xed_burst
    import xed_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire burst_t burst_in,
    input  wire logic   load_valid,
    output logic        load_ready,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    output byte_t       m_tdata,
    output logic        m_tlast
);

    byte_t [BurstDepth-1:0] slot_reg;
    byte_t [BurstDepth-1:0] slot_next;
    logic [2:0]             count_reg;
    logic [2:0]             count_next;
    logic                   last_reg;
    logic                   last_next;
    logic                   pop;
    logic                   load;

    assign m_tvalid   = (count_reg != 3'd0);
    assign m_tdata    = slot_reg[0];
    assign m_tlast    = last_reg && (count_reg == 3'd1);
    assign pop        = m_tvalid && m_tready;
    // take a new request when empty, or once the last waiting byte leaves in this cycle
    assign load_ready = (count_reg == 3'd0) || ((count_reg == 3'd1) && pop);
    assign load       = load_valid && load_ready;

    always_comb
    begin
        slot_next  = slot_reg;
        count_next = count_reg;
        last_next  = last_reg;
        if (load)
        begin
            slot_next  = burst_in.data;
            count_next = burst_in.count;
            last_next  = burst_in.last;
        end
        else if (pop)
        begin
            for (int j = 0; j < BurstDepth - 1; j++)
            begin
                slot_next[j] = slot_reg[j+1];
            end
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
            last_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

`default_nettype wire

>>> rtl/xml_entity_decoder_top.sv
// channel   dir  tdata            tlast     tuser
// s_*       in   [7:0] char_in    last_in   -
// m_*       out  [7:0] char_out   last_out  -
//
// one input byte per cycle while output drains one byte per cycle
// a flush after a mismatch or at stream end puts out 1 to 6 bytes,
// input waits until only the final byte of that flush remains
// the output burst register sits between both sides; s_tready follows m_tready
// in the same cycle while the final byte of a burst waits
// reset (rst_n low) clears the pending prefix and empties the output
`timescale 1ns / 1ps
`default_nettype none

module xml_entity_decoder_top
    import xed_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // char_in[7:0]
    input  wire logic       s_tlast,    // last_in
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // char_out[7:0]
    output logic            m_tlast     // last_out
);

    logic                   in_entity_reg;
    logic                   in_entity_next;
    logic [2:0]             prefix_count_reg;
    logic [2:0]             prefix_count_next;
    byte_t [PrefixDepth-1:0] prefix_bytes_reg;
    byte_t [PrefixDepth-1:0] prefix_bytes_next;
    burst_t                 burst;
    state_upd_t             upd;
    logic                   accept;

    assign accept = s_tvalid && s_tready;

    xed_match u_match (
        .in_entity    (in_entity_reg),
        .prefix_count (prefix_count_reg),
        .prefix_bytes (prefix_bytes_reg),
        .char_in      (s_tdata),
        .last_in      (s_tlast),
        .burst        (burst),
        .upd          (upd)
    );

    xed_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .burst_in   (burst),
        .load_valid (s_tvalid),
        .load_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    always_comb
    begin
        in_entity_next    = in_entity_reg;
        prefix_count_next = prefix_count_reg;
        prefix_bytes_next = prefix_bytes_reg;
        if (accept)
        begin
            in_entity_next    = upd.in_entity;
            prefix_count_next = upd.count;
            if (upd.wr_en)
            begin
                prefix_bytes_next[upd.wr_idx] = s_tdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_entity_reg    <= 1'b0;
            prefix_count_reg <= 3'd0;
        end
        else
        begin
            in_entity_reg    <= in_entity_next;
            prefix_count_reg <= prefix_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prefix_bytes_reg <= prefix_bytes_next;
    end

endmodule

`default_nettype wire

>>> rtl/xed_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "xml_entity_decoder_top_macros.svh"

module xed_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    logic s_acc;
    logic in_last_seen;

    assign s_acc        = s_tvalid && s_tready;
    assign in_last_seen = s_acc && s_tlast;

    // a stalled result holds its byte and marker
    `XED_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    // empty output side always takes a request
    `XED_ASSERT_NOW(a_empty_ready, !m_tvalid, s_tready)
    // no new request while a result waits and is not taken
    `XED_ASSERT_NOW(a_stall_blocks, m_tvalid && !m_tready, !s_tready)
    // end of stream always produces output
    `XED_ASSERT_NEXT(a_last_outputs, in_last_seen, m_tvalid)

endmodule

bind xml_entity_decoder_top xed_checker u_xed_checker (.*);

`default_nettype wire

>>> bench/xed_decode_checker.sv
`timescale 1ns / 1ps

module xed_decode_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,    // char_in[7:0]
    input  logic       s_tlast,    // last_in
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,    // char_out[7:0]
    input  logic       m_tlast,    // last_out
    output int         errors,
    output int         outstanding,
    output int         n_results,
    output int         n_decoded,
    output int         n_flushed
);

    localparam int NumEnt   = 5;
    localparam int HoldSize = 4;

    // entity names after the ampersand, zero padded
    localparam logic [7:0] ENT_TEXT [NumEnt][5] = '{
        '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
        '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
        '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
        '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
        '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b}
    };
    localparam int ENT_SIZE [NumEnt] = '{3, 3, 4, 5, 5};
    localparam logic [7:0] ENT_CHAR [NumEnt] = '{8'h3c, 8'h3e, 8'h26, 8'h27, 8'h22};

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } out_byte_t;

    out_byte_t  decoded_q [$];

    logic       amp_open;
    int         held;
    logic [7:0] held_bytes [HoldSize];

    initial
    begin
        errors      = 0;
        outstanding = 0;
        n_results   = 0;
        n_decoded   = 0;
        n_flushed   = 0;
        amp_open    = 1'b0;
        held        = 0;
    end

    task automatic decode_byte(input logic [7:0] c, input logic fin);
        logic [7:0] obuf [6];
        int         n;
        int         full;
        int         spill;
        bit         partial;
        bit         ok;
        bit         done;
        out_byte_t  item;
        n       = 0;
        full    = -1;
        spill   = -1;
        partial = 0;
        done    = 0;
        if (amp_open)
        begin
            for (int e = 0; e < NumEnt; e++)
            begin
                if (ENT_SIZE[e] > held)
                begin
                    ok = 1;
                    for (int i = 0; i < held; i++)
                        if (held_bytes[i] != ENT_TEXT[e][i])
                            ok = 0;
                    if (ok && ENT_TEXT[e][held] == c)
                    begin
                        if (held + 1 == ENT_SIZE[e])
                            full = e;
                        else
                            partial = 1;
                    end
                end
            end
            if (full >= 0)
            begin
                obuf[n] = ENT_CHAR[full];
                n++;
                amp_open = 1'b0;
                held = 0;
                done = 1;
                n_decoded++;
            end
            else if (partial && held < HoldSize)
            begin
                held_bytes[held] = c;
                held++;
                // stream ends inside a prefix: give it all back as typed
                if (fin)
                    spill = held;
                done = 1;
            end
            else
            begin
                spill = held;
                amp_open = 1'b0;
                held = 0;
            end
        end
        if (spill >= 0)
        begin
            obuf[n] = xed_pkg::AMP_CHAR;
            n++;
            for (int i = 0; i < spill; i++)
            begin
                obuf[n] = held_bytes[i];
                n++;
            end
            n_flushed++;
        end
        if (!done)
        begin
            if (c == xed_pkg::AMP_CHAR)
            begin
                if (fin)
                begin
                    obuf[n] = c;
                    n++;
                end
                else
                begin
                    amp_open = 1'b1;
                    held = 0;
                end
            end
            else
            begin
                obuf[n] = c;
                n++;
            end
        end
        if (fin)
        begin
            amp_open = 1'b0;
            held = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            item.ch  = obuf[i];
            item.fin = fin && (i == n - 1);
            decoded_q.push_back(item);
        end
    endtask

    always @(posedge clk)
    begin
        out_byte_t want;
        if (!rst_n)
        begin
            amp_open = 1'b0;
            held = 0;
        end
        else
        begin
            // predict first: a result never comes from a request in the same cycle
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (decoded_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected output %02h last %0b",
                                 $realtime, m_tdata, m_tlast);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (m_tdata !== want.ch || m_tlast !== want.fin)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: expected %02h last %0b, got %02h last %0b",
                                     $realtime, want.ch, want.fin, m_tdata, m_tlast);
                    end
                end
            end
        end
        outstanding = decoded_q.size();
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;    // char_in[7:0]
    logic       s_tlast  = 1'b0;     // last_in
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;             // char_out[7:0]
    logic       m_tlast;             // last_out

    int errors, outstanding, n_results, n_decoded, n_flushed;

    logic s_fire = 1'b0;
    int   tx_idle   = 15;
    int   rx_idle   = 78;
    int   hold_reqs = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   sent      = 0;
    int   holds     = 0;

    string ent_txt [5] = '{"lt;", "gt;", "amp;", "apos;", "quot;"};
    string junk = "&;alptgmoqus";

    xml_entity_decoder_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    xed_decode_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .errors      (errors),
        .outstanding (outstanding),
        .n_results   (n_results),
        .n_decoded   (n_decoded),
        .n_flushed   (n_flushed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // handshake seen at the rising edge, read back at the next falling edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_fire <= 1'b0;
        else
            s_fire <= s_tvalid && s_tready;
    end

    // output side: random stalls, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = 80;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle);
    end

    function automatic logic pick_last();
        return $urandom_range(99) < 5;
    endfunction

    // starts and returns just after a falling edge
    task automatic push_byte(input logic [7:0] c, input logic fin);
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        @(negedge clk);
        while (!s_fire)
            @(negedge clk);
        sent++;
    endtask

    task automatic push_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], fin && (i == s.len() - 1));
    endtask

    // well-formed entities most often, then broken prefixes, loose bytes and ampersands
    task automatic push_token();
        int    pick;
        int    cut;
        string s;
        pick = $urandom_range(99);
        s = ent_txt[$urandom_range(4)];
        if (pick < 40)
        begin
            push_byte(xed_pkg::AMP_CHAR, pick_last());
            for (int i = 0; i < s.len(); i++)
                push_byte(s[i], pick_last());
        end
        else if (pick < 62)
        begin
            cut = $urandom_range(s.len() - 1);
            push_byte(xed_pkg::AMP_CHAR, pick_last());
            for (int i = 0; i < cut; i++)
                push_byte(s[i], pick_last());
            if ($urandom_range(1))
                push_byte(8'($urandom_range(255)), pick_last());
            else
                push_byte(junk[$urandom_range(junk.len() - 1)], pick_last());
        end
        else if (pick < 90)
            push_byte(8'($urandom_range(255)), pick_last());
        else
            push_byte(xed_pkg::AMP_CHAR, pick_last());
    endtask

    // sender goes quiet until every expected result is out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // corner bytes, each entity kind of path, restart on a second ampersand,
        // end of stream inside a prefix and on a lone ampersand
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b1);
        push_text("&lt;", 1'b0);
        push_text("&am&gt;", 1'b0);
        push_text("&quot;", 1'b0);
        push_text("&apos", 1'b1);
        push_text("&", 1'b1);

        while (sent < 175)
            push_token();
        push_byte(8'h2e, 1'b1);
        drain();

        tx_idle = 78;
        rx_idle = 15;
        while (sent < 325)
            push_token();
        push_byte(8'h2e, 1'b1);
        drain();

        tx_idle = 0;
        rx_idle = 0;
        while (sent < 360)
            push_token();
        // stall the output and keep offering requests until the input backs up
        hold_reqs++;
        holds++;
        while (sent < 420)
            push_token();
        drain();
        while (sent < 465)
            push_token();
        push_byte(8'h2e, 1'b1);
        s_tvalid <= 1'b0;

        drain();
        repeat (20) @(negedge clk);

        $display("%0d bytes in, %0d bytes out, %0d entities replaced, %0d prefixes given back",
                 sent, n_results, n_decoded, n_flushed);
        $display("three stall patterns, %0d long output hold-off, full drains between parts",
                 holds);
        if (errors == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
